// ===== src/hcbp_pkg.sv =====
// Shared types, constants and codes for the Huffman code bit packer.
package hcbp_pkg;

  localparam int MAX_CODE_LEN = 32;
  localparam int SYMBOL_COUNT = 256;

  localparam int WORD_W  = 32;
  localparam int LEN_W   = 6;
  localparam int SYM_W   = 8;
  localparam int MODE_W  = 2;
  localparam int BYTE_W  = 8;

  // longest code that can actually be stored
  localparam int LEN_CAP = (MAX_CODE_LEN < WORD_W) ? MAX_CODE_LEN : WORD_W;
  // pending bits (at most seven) plus one code, left aligned
  localparam int ACC_W   = LEN_CAP + BYTE_W;
  localparam int CNT_W   = $clog2(ACC_W + 1);
  localparam int ADDR_W  = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int ENTRY_W = LEN_W + WORD_W;

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ENCODE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FLUSH  = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [SYM_W-1:0]  symbol;
    logic [WORD_W-1:0] code_word;
    logic [LEN_W-1:0]  code_length;
  } hcbp_cmd_t;

  typedef struct packed {
    logic             idle;
    logic [CNT_W-1:0] cnt;
  } hcbp_status_t;

endpackage

// ===== src/hcbp_ram.sv =====
// Generic single-port RAM with registered read data.
module hcbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/hcbp_front.sv =====
// Input side: takes beats, drops no-op items, tidies loads and queues the rest.
module hcbp_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [hcbp_pkg::MODE_W-1:0] in_mode,
  input  logic [hcbp_pkg::SYM_W-1:0]  in_symbol,
  input  logic [hcbp_pkg::WORD_W-1:0] in_code_word,
  input  logic [hcbp_pkg::LEN_W-1:0]  in_code_length,
  output hcbp_pkg::hcbp_cmd_t         head,
  output logic                       head_valid,
  input  logic                       pop
);
  import hcbp_pkg::*;

  hcbp_cmd_t          q_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;

  logic               full;
  logic               accept;
  logic               keep;
  logic               push;
  logic               in_range;
  logic [LEN_W-1:0]   len_sat;
  hcbp_cmd_t          cmd;

  assign full       = (cnt_r == QCNT_W'(QDEPTH));
  assign in_stall   = full;
  assign head_valid = (cnt_r != '0);
  assign head       = q_r[rd_ptr_r];
  assign accept     = in_valid && !in_stall;

  always_comb begin
    in_range = ({1'b0, in_symbol} < (SYM_W+1)'(SYMBOL_COUNT));
    len_sat  = (in_code_length > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : in_code_length;
    case (in_mode)
      MODE_LOAD, MODE_ENCODE: keep = in_range;
      MODE_FLUSH:             keep = 1'b1;
      default:                keep = 1'b0;
    endcase
    cmd.mode        = in_mode;
    cmd.symbol      = in_symbol;
    // bits above the code length would spill into the pending bits later
    cmd.code_word   = in_code_word & ~({WORD_W{1'b1}} << len_sat);
    cmd.code_length = len_sat;
  end

  assign push = accept && keep;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cmd;
    end
  end

endmodule

// ===== src/hcbp_back.sv =====
// Execution side: table writes, code lookup, bit packing and byte output.
module hcbp_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  hcbp_pkg::hcbp_cmd_t           head,
  input  logic                          head_valid,
  output logic                          pop,
  output logic                          ram_we,
  output logic [hcbp_pkg::ADDR_W-1:0]   ram_addr,
  output logic [hcbp_pkg::ENTRY_W-1:0]  ram_wdata,
  input  logic [hcbp_pkg::ENTRY_W-1:0]  ram_rdata,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [hcbp_pkg::BYTE_W-1:0]   out_byte,
  output logic                          out_last_of_run,
  output hcbp_pkg::hcbp_status_t        status
);
  import hcbp_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MERGE = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic              out_last_r, out_last_nxt;

  logic              out_free;
  logic [WORD_W-1:0] code;
  logic [LEN_W-1:0]  len;
  logic [CNT_W-1:0]  sh;

  assign code = ram_rdata[WORD_W-1:0];
  assign len  = ram_rdata[ENTRY_W-1:WORD_W];
  // code lands just below the pending bits, left aligned overall
  assign sh   = CNT_W'(ACC_W) - cnt_r - CNT_W'(len);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    pop           = 1'b0;
    ram_we        = 1'b0;
    ram_addr      = head.symbol[ADDR_W-1:0];
    ram_wdata     = {head.code_length, head.code_word};

    case (state_r)
      ST_IDLE: begin
        if (head_valid) begin
          case (head.mode)
            MODE_LOAD: begin
              ram_we = 1'b1;
              pop    = 1'b1;
            end
            MODE_ENCODE: begin
              pop       = 1'b1;
              state_nxt = ST_MERGE;
            end
            MODE_FLUSH: begin
              if (cnt_r == '0) begin
                pop = 1'b1;
              end else if (out_free) begin
                pop           = 1'b1;
                out_valid_nxt = 1'b1;
                out_byte_nxt  = acc_r[ACC_W-1 -: BYTE_W];
                out_last_nxt  = 1'b1;
                acc_nxt       = '0;
                cnt_nxt       = '0;
              end
            end
            default: pop = 1'b1;
          endcase
        end
      end
      ST_MERGE: begin
        acc_nxt   = acc_r | (ACC_W'(code) << sh);
        cnt_nxt   = cnt_r + CNT_W'(len);
        state_nxt = (cnt_nxt >= CNT_W'(BYTE_W)) ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = acc_r[ACC_W-1 -: BYTE_W];
          out_last_nxt  = (cnt_r < CNT_W'(2 * BYTE_W));
          acc_nxt       = acc_r << BYTE_W;
          cnt_nxt       = cnt_r - CNT_W'(BYTE_W);
          if (cnt_r < CNT_W'(2 * BYTE_W)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      acc_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_last_of_run = out_last_r;
  assign status.idle     = (state_r == ST_IDLE);
  assign status.cnt      = cnt_r;

endmodule

// ===== src/huffman_code_bit_packer_top.sv =====
// Top level of the Huffman code bit packer: front queue, code table and packer.
//
// Items enter a two-beat queue and are carried out one at a time. A load is a
// write to the single-port 256-entry code table. An encode reads the table,
// then merges the code into the pending bits, then emits each completed byte;
// the bytes leave through the output register at one per cycle while the
// output is not stalled. The queue keeps the input side taking beats while
// the output side is stalled, until the queue is full.
// Table entries are undefined until loaded; there is no clearing pass.
module huffman_code_bit_packer_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [hcbp_pkg::MODE_W-1:0] in_mode,
  input  logic [hcbp_pkg::SYM_W-1:0]  in_symbol,
  input  logic [hcbp_pkg::WORD_W-1:0] in_code_word,
  input  logic [hcbp_pkg::LEN_W-1:0]  in_code_length,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [hcbp_pkg::BYTE_W-1:0] out_byte,
  output logic                        out_last_of_run
);
  import hcbp_pkg::*;

  hcbp_cmd_t           head;
  logic                head_valid;
  logic                pop;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_addr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [ENTRY_W-1:0]  ram_rdata;
  hcbp_status_t        status;

  hcbp_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_symbol      (in_symbol),
    .in_code_word   (in_code_word),
    .in_code_length (in_code_length),
    .head           (head),
    .head_valid     (head_valid),
    .pop            (pop)
  );

  hcbp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SYMBOL_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  hcbp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .head_valid      (head_valid),
    .pop             (pop),
    .ram_we          (ram_we),
    .ram_addr        (ram_addr),
    .ram_wdata       (ram_wdata),
    .ram_rdata       (ram_rdata),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run),
    .status          (status)
  );

  // never take from an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("pop from empty queue");

  // between items fewer than eight bits may be pending
  a_idle_partial: assert property (@(posedge clk) disable iff (!rst_n)
    status.idle |-> (status.cnt < CNT_W'(BYTE_W)))
    else $error("full byte left pending while idle");

  // accumulator never overfills
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    status.cnt <= CNT_W'(ACC_W))
    else $error("pending bit count out of range");

  // a table write is always a queue pop
  a_we_pops: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (pop && head.mode == MODE_LOAD))
    else $error("table write without a load beat");

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the Huffman code bit packer: table loads, encodes and flushes.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hcbp_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam int unsigned N_RANDOM  = 330;
  localparam int unsigned HOLD_AT   = 60;
  localparam int unsigned HOLD_LEN  = 200;
  localparam int unsigned DRAIN_CYC = 40;

  typedef struct {
    hcbp_cmd_t   cmd;
    int unsigned gap;
  } beat_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } packed_byte_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [MODE_W-1:0] in_mode = MODE_LOAD;
  logic [SYM_W-1:0]  in_symbol = '0;
  logic [WORD_W-1:0] in_code_word = '0;
  logic [LEN_W-1:0]  in_code_length = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [BYTE_W-1:0] out_byte;
  logic              out_last_of_run;

  huffman_code_bit_packer_top u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_symbol       (in_symbol),
    .in_code_word    (in_code_word),
    .in_code_length  (in_code_length),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // packer mirror: code table plus the partial byte
  logic [WORD_W-1:0] code_mem [SYMBOL_COUNT];
  logic [LEN_W-1:0]  len_mem  [SYMBOL_COUNT];
  logic [BYTE_W-1:0] part_byte = '0;
  int unsigned       part_bits = 0;

  beat_t        beat_q [$];
  packed_byte_t byte_q [$];

  int unsigned cur_gap = 0;
  int unsigned wait_left = 0;
  int unsigned rx_wait = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  int unsigned bytes_seen = 0;
  int unsigned n_errors = 0;
  int unsigned n_mode [4] = '{0, 0, 0, 0};

  // generation-side view of which symbols hold a loaded entry
  logic        gen_loaded [SYMBOL_COUNT];
  int unsigned gen_syms [$];

  task automatic pack_beat(input hcbp_cmd_t c);
    logic [WORD_W-1:0] code;
    int unsigned       len, n_out, k, i;
    packed_byte_t      e;
    n_mode[c.mode]++;
    case (c.mode)
      MODE_LOAD: begin
        len = c.code_length;
        if (len > LEN_CAP) len = LEN_CAP;
        code_mem[c.symbol] = c.code_word;
        len_mem[c.symbol] = LEN_W'(len);
      end
      MODE_ENCODE: begin
        code = code_mem[c.symbol];
        len = len_mem[c.symbol];
        n_out = (part_bits + len) / 8;
        k = 0;
        for (i = len; i > 0; i--) begin
          part_byte = {part_byte[BYTE_W-2:0], code[i-1]};
          part_bits++;
          if (part_bits == 8) begin
            e.data = part_byte;
            e.last = (k == n_out - 1);
            byte_q.push_back(e);
            k++;
            part_byte = '0;
            part_bits = 0;
          end
        end
      end
      MODE_FLUSH: begin
        if (part_bits != 0) begin
          e.data = part_byte << (8 - part_bits);
          e.last = 1'b1;
          byte_q.push_back(e);
          part_byte = '0;
          part_bits = 0;
        end
      end
      default: ;
    endcase
  endtask

  function automatic int unsigned pick_gap(input int unsigned idx);
    if (idx >= 120 && idx < 180) return 0;  // back-to-back stretch
    if ($urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 10);
  endfunction

  function automatic beat_t mk_beat(input logic [MODE_W-1:0] mode, input logic [SYM_W-1:0] sym,
                                    input logic [WORD_W-1:0] word, input logic [LEN_W-1:0] len);
    beat_t b;
    b.cmd.mode = mode;
    b.cmd.symbol = sym;
    b.cmd.code_word = word;
    b.cmd.code_length = len;
    b.gap = pick_gap(beat_q.size());
    return b;
  endfunction

  function automatic logic [LEN_W-1:0] pick_len();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r < 15) return LEN_W'($urandom_range(1, 12));
    if (r < 18) return LEN_W'($urandom_range(13, 32));
    return LEN_W'($urandom_range(33, 63));  // saturated on load
  endfunction

  task automatic add_load(input logic [SYM_W-1:0] sym, input logic [WORD_W-1:0] word,
                          input logic [LEN_W-1:0] len);
    beat_q.push_back(mk_beat(MODE_LOAD, sym, word, len));
    if (!gen_loaded[sym]) begin
      gen_loaded[sym] = 1'b1;
      gen_syms.push_back(sym);
    end
  endtask

  // sender: one beat in flight, per-beat idle gap after acceptance
  always @(posedge clk) begin : drive
    beat_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      wait_left <= 0;
    end else begin
      if (in_valid && !in_stall)
        pack_beat({in_mode, in_symbol, in_code_word, in_code_length});
      if (in_valid && in_stall) begin
        // hold the beat steady
      end else if (in_valid && cur_gap != 0) begin
        in_valid <= 1'b0;
        wait_left <= cur_gap - 1;
      end else if (!in_valid && wait_left != 0) begin
        wait_left <= wait_left - 1;
      end else if (beat_q.size() != 0) begin
        nxt = beat_q.pop_front();
        in_valid <= 1'b1;
        in_mode <= nxt.cmd.mode;
        in_symbol <= nxt.cmd.symbol;
        in_code_word <= nxt.cmd.code_word;
        in_code_length <= nxt.cmd.code_length;
        cur_gap <= nxt.gap;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // one long back-pressure window early in the run
  always @(posedge clk) begin : hold_ctl
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && bytes_seen >= HOLD_AT) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver and checker
  always @(posedge clk) begin : monitor
    int unsigned  w;
    packed_byte_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_wait <= 0;
    end else begin
      w = rx_wait;
      if (out_valid && !out_stall) begin
        if (byte_q.size() == 0) begin
          $error("out_byte: unexpected beat %02h with nothing outstanding", out_byte);
          n_errors++;
        end else begin
          want = byte_q.pop_front();
          if (out_byte !== want.data) begin
            $error("out_byte: expected %02h, got %02h", want.data, out_byte);
            n_errors++;
          end
          if (out_last_of_run !== want.last) begin
            $error("out_last_of_run: expected %0b, got %0b", want.last, out_last_of_run);
            n_errors++;
          end
        end
        bytes_seen <= bytes_seen + 1;
        if (bytes_seen >= 150 && bytes_seen < 230) w = 0;
        else if ($urandom_range(0, 3) == 0) w = 0;
        else w = $urandom_range(0, 10);
      end else if (w != 0) begin
        w--;
      end
      rx_wait <= w;
      out_stall <= (w != 0) || (hold_left != 0);
    end
  end

  initial begin : stimulus
    int unsigned counted, r, s;
    foreach (gen_loaded[i]) gen_loaded[i] = 1'b0;

    // directed: table extremes, saturation, empty and partial flushes, spare mode
    add_load(8'd0, 32'hFFFF_FFFF, 6'd32);
    add_load(8'd255, 32'h0000_0000, 6'd0);
    add_load(8'd1, 32'h0000_00A5, 6'd63);
    add_load(8'd2, 32'h0000_0005, 6'd3);
    add_load(8'd3, 32'h0000_0001, 6'd1);
    add_load(8'd4, 32'h8000_0001, 6'd33);
    add_load(8'd5, 32'h0000_007F, 6'd7);
    beat_q.push_back(mk_beat(MODE_FLUSH, 8'hFF, 32'hFFFF_FFFF, 6'h3F));
    beat_q.push_back(mk_beat(MODE_SPARE, 8'hAA, 32'h5555_AAAA, 6'h2A));
    beat_q.push_back(mk_beat(MODE_ENCODE, 8'd255, 32'hFFFF_FFFF, 6'h3F));
    beat_q.push_back(mk_beat(MODE_ENCODE, 8'd2, 32'h0, 6'd0));
    beat_q.push_back(mk_beat(MODE_FLUSH, 8'd0, 32'h0, 6'd0));
    beat_q.push_back(mk_beat(MODE_ENCODE, 8'd5, 32'h0, 6'd0));
    beat_q.push_back(mk_beat(MODE_ENCODE, 8'd0, 32'h0, 6'd0));
    beat_q.push_back(mk_beat(MODE_ENCODE, 8'd4, 32'h0, 6'd0));
    beat_q.push_back(mk_beat(MODE_ENCODE, 8'd3, 32'h0, 6'd0));
    beat_q.push_back(mk_beat(MODE_FLUSH, 8'd0, 32'h0, 6'd0));
    beat_q.push_back(mk_beat(MODE_ENCODE, 8'd1, 32'h0, 6'd0));
    beat_q.push_back(mk_beat(MODE_ENCODE, 8'd0, 32'h0, 6'd0));
    beat_q.push_back(mk_beat(MODE_FLUSH, 8'd0, 32'h0, 6'd0));

    // random: mostly encodes of loaded symbols, loads interleaved, some noise
    counted = 0;
    while (counted < N_RANDOM) begin
      r = $urandom_range(0, 99);
      if (r < 25) begin
        add_load(SYM_W'($urandom_range(0, 255)), $urandom, pick_len());
        counted++;
      end else if (r < 85) begin
        s = gen_syms[$urandom_range(0, gen_syms.size() - 1)];
        beat_q.push_back(mk_beat(MODE_ENCODE, SYM_W'(s), $urandom, LEN_W'($urandom)));
        counted++;
      end else if (r < 97) begin
        beat_q.push_back(mk_beat(MODE_FLUSH, SYM_W'($urandom), $urandom, LEN_W'($urandom)));
        counted++;
      end else begin
        beat_q.push_back(mk_beat(MODE_SPARE, SYM_W'($urandom), $urandom, LEN_W'($urandom)));
      end
    end
    beat_q.push_back(mk_beat(MODE_FLUSH, 8'd0, 32'h0, 6'd0));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (beat_q.size() != 0 || in_valid) @(posedge clk);
    while (byte_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("Sent %0d loads, %0d encodes, %0d flushes and %0d spare-mode beats;",
             n_mode[MODE_LOAD], n_mode[MODE_ENCODE], n_mode[MODE_FLUSH], n_mode[MODE_SPARE]);
    $display("checked %0d packed bytes with %0d mismatches.", bytes_seen, n_errors);
    if (n_errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin : watchdog
    #1_000_000;
    $display("Timed out with %0d bytes still outstanding", byte_q.size());
    $display("FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
src/hcbp_pkg.sv
src/hcbp_ram.sv
src/hcbp_front.sv
src/hcbp_back.sv
src/huffman_code_bit_packer_top.sv
dv/testbench.sv
